[rtl/core/omnq_pkg.sv]
// Package for the ordered map neighbor query block.
// Holds the command codes, the internal operation type, the queue item, the back state type and constants.
// Used by every file in rtl/core.
package omnq_pkg;

    localparam int KEY_W = 32;
    localparam int VAL_W = 32;

    localparam logic [1:0] CMD_INSERT   = 2'd0;
    localparam logic [1:0] CMD_CONTAINS = 2'd1;
    localparam logic [1:0] CMD_LARGER   = 2'd2;
    localparam logic [1:0] CMD_SMALLER  = 2'd3;

    localparam logic signed [KEY_W-1:0] KEY_MAX  = 32'sh7FFF_FFFF;
    localparam logic signed [KEY_W-1:0] KEY_MIN  = 32'sh8000_0000;
    localparam logic signed [VAL_W-1:0] VAL_NONE = -32'sd1;

    typedef enum logic [1:0] {
        OP_INSERT,
        OP_CONTAINS,
        OP_LARGER,
        OP_SMALLER
    } op_t;

    typedef struct packed {
        op_t                      op;
        logic signed [KEY_W-1:0]  key;
        logic signed [VAL_W-1:0]  val;
    } q_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } back_state_t;

endpackage

[rtl/core/omnq_if.sv]
// Handshake interfaces for the request and response channels.
// Depends on omnq_pkg for field widths.
interface omnq_req_if
    import omnq_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [1:0]              cmd;
    logic signed [KEY_W-1:0] key;
    logic signed [VAL_W-1:0] entry_value;

    modport source (output valid, cmd, key, entry_value, input ready);
    modport sink   (input valid, cmd, key, entry_value, output ready);
endinterface

interface omnq_rsp_if
    import omnq_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic                    found;
    logic signed [KEY_W-1:0] neighbor_key;
    logic signed [VAL_W-1:0] neighbor_value;
    logic                    table_full;

    modport source (output valid, found, neighbor_key, neighbor_value, table_full,
                    input ready);
    modport sink   (input valid, found, neighbor_key, neighbor_value, table_full,
                    output ready);
endinterface

[rtl/core/omnq_front.sv]
// Front part: accepts request items, decodes the command and queues them.
// Two-entry queue toward the back part. Depends on omnq_pkg and omnq_if.
module omnq_front
    import omnq_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    omnq_req_if.sink        req,
    output logic            q_valid,
    input  logic            q_ready,
    output q_item_t         q_item
);

    q_item_t    slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop;
    op_t        op_dec;

    always_comb
    begin
        case (req.cmd)
            CMD_INSERT:   op_dec = OP_INSERT;
            CMD_CONTAINS: op_dec = OP_CONTAINS;
            CMD_LARGER:   op_dec = OP_LARGER;
            CMD_SMALLER:  op_dec = OP_SMALLER;
            default:      op_dec = OP_INSERT;
        endcase
    end

    assign req.ready = (cnt_reg != 2'd2);
    assign push      = req.valid && req.ready;
    assign q_valid   = (cnt_reg != 2'd0);
    assign pop       = q_valid && q_ready;
    assign q_item    = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= '{op: op_dec, key: req.key, val: req.entry_value};
        end
    end

endmodule

[rtl/core/omnq_back.sv]
// Back part: holds the key and value memories, scans them once per item
// and drives the registered response. Depends on omnq_pkg and omnq_if.
module omnq_back
    import omnq_pkg::*;
#(
    parameter int CAPACITY = 64
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    output logic            q_ready,
    input  q_item_t         q_item,
    omnq_rsp_if.source      rsp
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    logic signed [KEY_W-1:0] key_mem [CAPACITY];
    logic signed [VAL_W-1:0] val_mem [CAPACITY];

    back_state_t state_reg, state_next;

    logic [CW-1:0]           count_reg;
    logic [CW-1:0]           iss_reg;
    logic                    pend_reg;
    logic [AW-1:0]           pend_idx_reg;
    logic signed [KEY_W-1:0] rd_key_reg;
    logic signed [VAL_W-1:0] rd_val_reg;

    q_item_t                 cur_reg;
    logic                    hit_reg;
    logic [AW-1:0]           hit_idx_reg;
    logic signed [VAL_W-1:0] hit_val_reg;
    logic                    best_reg;
    logic signed [KEY_W-1:0] best_key_reg;
    logic signed [VAL_W-1:0] best_val_reg;

    logic                    ovalid_reg;
    logic                    ofound_reg;
    logic signed [KEY_W-1:0] okey_reg;
    logic signed [VAL_W-1:0] oval_reg;
    logic                    ofull_reg;

    logic issue, start, finish, out_free;
    logic is_eq, better;
    logic res_found, res_full;
    logic signed [KEY_W-1:0] res_key;
    logic signed [VAL_W-1:0] res_val;
    logic wr_over, wr_new;

    assign issue    = (state_reg == ST_SCAN) && (iss_reg < count_reg);
    assign out_free = !ovalid_reg || rsp.ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (q_valid)
                    state_next = ST_SCAN;
            ST_SCAN:
                if (!issue && !pend_reg)
                    state_next = ST_DONE;
            ST_DONE:
                if (out_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        start  = 1'b0;
        finish = 1'b0;
        case (state_reg)
            ST_IDLE: start  = q_valid;
            ST_SCAN: ;
            ST_DONE: finish = out_free;
            default: ;
        endcase
    end

    assign q_ready = start;

    // compare the entry read last cycle
    always_comb
    begin
        is_eq  = (rd_key_reg == cur_reg.key);
        better = 1'b0;
        if (cur_reg.op == OP_LARGER)
            better = (rd_key_reg > cur_reg.key) && (!best_reg || rd_key_reg < best_key_reg);
        else if (cur_reg.op == OP_SMALLER)
            better = (rd_key_reg < cur_reg.key) && (!best_reg || rd_key_reg > best_key_reg);
    end

    // result of the finished scan
    always_comb
    begin
        res_found = 1'b0;
        res_full  = 1'b0;
        res_key   = cur_reg.key;
        res_val   = VAL_NONE;
        wr_over   = 1'b0;
        wr_new    = 1'b0;
        case (cur_reg.op)
            OP_INSERT:
            begin
                if (hit_reg)
                begin
                    res_found = 1'b1;
                    res_val   = cur_reg.val;
                    wr_over   = 1'b1;
                end
                else if (count_reg != CAP_C)
                begin
                    res_found = 1'b1;
                    res_val   = cur_reg.val;
                    wr_new    = 1'b1;
                end
                else
                begin
                    res_full = 1'b1;
                end
            end
            OP_CONTAINS:
            begin
                res_found = hit_reg;
                if (hit_reg)
                    res_val = hit_val_reg;
            end
            OP_LARGER, OP_SMALLER:
            begin
                res_found = best_reg;
                if (best_reg)
                begin
                    res_key = best_key_reg;
                    res_val = best_val_reg;
                end
                else
                begin
                    res_key = (cur_reg.op == OP_LARGER) ? KEY_MAX : KEY_MIN;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            iss_reg    <= '0;
            pend_reg   <= 1'b0;
            hit_reg    <= 1'b0;
            best_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= issue;
            if (start)
            begin
                iss_reg  <= '0;
                hit_reg  <= 1'b0;
                best_reg <= 1'b0;
            end
            else
            begin
                if (issue)
                    iss_reg <= iss_reg + 1'b1;
                if (pend_reg && is_eq)
                    hit_reg <= 1'b1;
                if (pend_reg && better)
                    best_reg <= 1'b1;
            end
            if (finish && finish && wr_new)
                count_reg <= count_reg + 1'b1;
            if (finish)
                ovalid_reg <= 1'b1;
            else if (rsp.ready)
                ovalid_reg <= 1'b0;
        end
    end

    // datapath and memories
    always_ff @(posedge clk)
    begin
        if (start)
            cur_reg <= q_item;
        if (issue)
        begin
            rd_key_reg   <= key_mem[iss_reg[AW-1:0]];
            rd_val_reg   <= val_mem[iss_reg[AW-1:0]];
            pend_idx_reg <= iss_reg[AW-1:0];
        end
        if (pend_reg && is_eq)
        begin
            hit_idx_reg <= pend_idx_reg;
            hit_val_reg <= rd_val_reg;
        end
        if (pend_reg && better)
        begin
            best_key_reg <= rd_key_reg;
            best_val_reg <= rd_val_reg;
        end
        if (finish && wr_new)
        begin
            key_mem[count_reg[AW-1:0]] <= cur_reg.key;
            val_mem[count_reg[AW-1:0]] <= cur_reg.val;
        end
        else if (finish && wr_over)
        begin
            val_mem[hit_idx_reg] <= cur_reg.val;
        end
        if (finish)
        begin
            ofound_reg <= res_found;
            okey_reg   <= res_key;
            oval_reg   <= res_val;
            ofull_reg  <= res_full;
        end
    end

    assign rsp.valid          = ovalid_reg;
    assign rsp.found          = ofound_reg;
    assign rsp.neighbor_key   = okey_reg;
    assign rsp.neighbor_value = oval_reg;
    assign rsp.table_full     = ofull_reg;

endmodule

[rtl/core/ordered_map_neighbor_query.sv]
// Ordered map of up to CAPACITY signed 32-bit keys with values, empty after reset.
// Commands: insert/overwrite, contains, next larger key, next smaller key.
// A two-entry request queue feeds a scan engine that reads the key and value
// memories one entry per cycle and works on one item at a time. The response sits
// in an output register while the next item scans.
module ordered_map_neighbor_query
    import omnq_pkg::*;
#(
    parameter int CAPACITY = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    omnq_req_if.sink    req,
    omnq_rsp_if.source  rsp
);

    logic    q_valid;
    logic    q_ready;
    q_item_t q_item;

    omnq_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_item  (q_item)
    );

    omnq_back #(.CAPACITY(CAPACITY)) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_item  (q_item),
        .rsp     (rsp)
    );

endmodule

[rtl/core/omnq_checker.sv]
// Port-level checks on the response channel of the ordered map block.
// Bound to ordered_map_neighbor_query; depends on omnq_pkg.
module omnq_checker
    import omnq_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    valid,
    input logic                    ready,
    input logic                    found,
    input logic signed [KEY_W-1:0] neighbor_key,
    input logic signed [VAL_W-1:0] neighbor_value,
    input logic                    table_full
);

    a_full_not_found: assert property (@(posedge clk) disable iff (!rst_n)
        valid && table_full |-> !found)
        else $error("table_full with found set");

    a_miss_value: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !found |-> neighbor_value == VAL_NONE)
        else $error("miss without value of -1");

    a_full_value: assert property (@(posedge clk) disable iff (!rst_n)
        valid && table_full |-> neighbor_value == VAL_NONE)
        else $error("dropped insert without value of -1");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !ready |=> valid && $stable(neighbor_key) && $stable(neighbor_value))
        else $error("stalled response changed");

endmodule

bind ordered_map_neighbor_query omnq_checker u_omnq_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .valid          (rsp.valid),
    .ready          (rsp.ready),
    .found          (rsp.found),
    .neighbor_key   (rsp.neighbor_key),
    .neighbor_value (rsp.neighbor_value),
    .table_full     (rsp.table_full)
);

[sim/tb.sv]
// Testbench for ordered_map_neighbor_query: directed table, then random commands.
// Depends on omnq_pkg and the omnq_req_if / omnq_rsp_if interfaces in rtl/core.
`timescale 1ns / 1ps

module tb;
    import omnq_pkg::*;

    localparam int CAP = 64;

    typedef struct {
        logic [1:0]              cmd;
        logic signed [KEY_W-1:0] key;
        logic signed [VAL_W-1:0] val;
        bit                      typed;
        logic                    found;
        logic signed [KEY_W-1:0] nkey;
        logic signed [VAL_W-1:0] nval;
        logic                    full;
    } row_t;

    typedef struct {
        logic                    found;
        logic signed [KEY_W-1:0] nkey;
        logic signed [VAL_W-1:0] nval;
        logic                    full;
    } answer_t;

    logic clk;
    logic rst_n;
    omnq_req_if req ();
    omnq_rsp_if rsp ();

    ordered_map_neighbor_query #(.CAPACITY(CAP)) DUT
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    // Shadow map, insertion order like the block's slots.
    logic signed [KEY_W-1:0] map_keys[$];
    logic signed [VAL_W-1:0] map_vals[$];
    answer_t answers[$];
    row_t    script[$];
    int      errors;
    bit      stim_done;
    bit      hold_off;
    logic signed [KEY_W-1:0] key_pool[$];

    function automatic answer_t map_lookup(logic [1:0] cmd, logic signed [KEY_W-1:0] k,
                                           logic signed [VAL_W-1:0] v);
        answer_t a;
        int      slot;
        int      best;
        slot = -1;
        best = -1;
        a.found = 1'b0;
        a.nkey = k;
        a.nval = VAL_NONE;
        a.full = 1'b0;
        foreach (map_keys[i])
            if (map_keys[i] == k)
                slot = i;
        case (cmd)
            CMD_INSERT:
            begin
                if (slot >= 0)
                begin
                    map_vals[slot] = v;
                    a.found = 1'b1;
                    a.nval = v;
                end
                else if (map_keys.size() < CAP)
                begin
                    map_keys.insert(map_keys.size(), k);
                    map_vals.insert(map_vals.size(), v);
                    a.found = 1'b1;
                    a.nval = v;
                end
                else
                    a.full = 1'b1;
            end
            CMD_CONTAINS:
            begin
                if (slot >= 0)
                begin
                    a.found = 1'b1;
                    a.nval = map_vals[slot];
                end
            end
            default:
            begin
                foreach (map_keys[i])
                begin
                    if (cmd == CMD_LARGER && map_keys[i] > k &&
                        (best < 0 || map_keys[i] < map_keys[best]))
                        best = i;
                    if (cmd == CMD_SMALLER && map_keys[i] < k &&
                        (best < 0 || map_keys[i] > map_keys[best]))
                        best = i;
                end
                if (best >= 0)
                begin
                    a.found = 1'b1;
                    a.nkey = map_keys[best];
                    a.nval = map_vals[best];
                end
                else
                    a.nkey = (cmd == CMD_LARGER) ? KEY_MAX : KEY_MIN;
            end
        endcase
        return a;
    endfunction

    function automatic row_t plain(logic [1:0] c, logic signed [KEY_W-1:0] k,
                                   logic signed [VAL_W-1:0] v);
        row_t r;
        r = '{c, k, v, 1'b0, 1'b0, '0, '0, 1'b0};
        return r;
    endfunction

    function automatic row_t typed(logic [1:0] c, logic signed [KEY_W-1:0] k,
                                   logic signed [VAL_W-1:0] v, logic f,
                                   logic signed [KEY_W-1:0] nk,
                                   logic signed [VAL_W-1:0] nv, logic tf);
        row_t r;
        r = '{c, k, v, 1'b1, f, nk, nv, tf};
        return r;
    endfunction

    function automatic void add_row(row_t r);
        script.insert(script.size(), r);
    endfunction

    function automatic logic signed [KEY_W-1:0] pick_key();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 5 && key_pool.size() > 0)
            return key_pool[$urandom_range(0, key_pool.size() - 1)];
        if (sel < 7)
            return $signed(32'($urandom_range(0, 400)) - 32'sd200);
        if (sel == 7)
            return ($urandom_range(0, 1) == 1) ? KEY_MAX : KEY_MIN;
        return $signed($urandom());
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("ordered_map_neighbor_query verification failed");
        $finish;
    end

    // Directed rows: empty-map extremes first, then the extremes as keys, then keys around zero.
    initial
    begin
        add_row(typed(CMD_LARGER, KEY_MIN, 0, 0, KEY_MAX, VAL_NONE, 0));
        add_row(typed(CMD_SMALLER, KEY_MAX, 0, 0, KEY_MIN, VAL_NONE, 0));
        add_row(typed(CMD_CONTAINS, 0, 5, 0, 0, VAL_NONE, 0));
        add_row(typed(CMD_INSERT, KEY_MAX, -1, 1, KEY_MAX, -1, 0));
        add_row(typed(CMD_INSERT, KEY_MIN, KEY_MAX, 1, KEY_MIN, KEY_MAX, 0));
        add_row(typed(CMD_LARGER, KEY_MAX, 0, 0, KEY_MAX, VAL_NONE, 0));
        add_row(typed(CMD_SMALLER, KEY_MIN, 0, 0, KEY_MIN, VAL_NONE, 0));
        add_row(plain(CMD_INSERT, 0, 32'sh5555_5555));
        add_row(plain(CMD_INSERT, -1, 32'shAAAA_AAAA));
        add_row(plain(CMD_INSERT, 1, KEY_MIN));
        add_row(plain(CMD_LARGER, 0, 0));
        add_row(plain(CMD_SMALLER, 0, 0));
        add_row(plain(CMD_LARGER, -1, 0));
        add_row(plain(CMD_SMALLER, 1, 0));
        add_row(plain(CMD_LARGER, 5, 0));
        add_row(plain(CMD_SMALLER, -5, 0));
        add_row(plain(CMD_INSERT, 0, 77));
        add_row(plain(CMD_CONTAINS, 0, 0));
        add_row(plain(CMD_CONTAINS, 2, 0));
        add_row(plain(CMD_CONTAINS, KEY_MIN, 0));
    end

    // Valid stays high into the next item when no idle cycles are drawn.
    task automatic send_item(logic [1:0] c, logic signed [KEY_W-1:0] k,
                             logic signed [VAL_W-1:0] v);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid <= 1'b1;
        req.cmd <= c;
        req.key <= k;
        req.entry_value <= v;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        answers.insert(answers.size(), map_lookup(c, k, v));
    endtask

    // Sender
    initial
    begin
        row_t    r;
        answer_t a;
        int      n;
        logic [1:0] c;
        logic signed [KEY_W-1:0] k;
        rst_n = 1'b0;
        stim_done = 1'b0;
        errors = 0;
        req.valid <= 1'b0;
        req.cmd <= CMD_INSERT;
        req.key <= '0;
        req.entry_value <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (script[i])
        begin
            r = script[i];
            send_item(r.cmd, r.key, r.val);
            if (r.typed)
            begin
                // Overwrite the predicted answer with the one read off the table.
                a = '{r.found, r.nkey, r.nval, r.full};
                answers[answers.size() - 1] = a;
            end
        end
        // Random part: phases of mostly inserts to fill the store, then mixed.
        for (n = 0; n < 550; n++)
        begin
            if (n < 150)
                c = ($urandom_range(0, 9) < 7) ? CMD_INSERT : 2'($urandom_range(1, 3));
            else
                c = 2'($urandom_range(0, 3));
            k = pick_key();
            if (c == CMD_INSERT)
                key_pool.insert(key_pool.size(), k);
            send_item(c, k, $signed($urandom()));
        end
        req.valid <= 1'b0;
        stim_done = 1'b1;
    end

    // Long receiver stall once, after the store has some entries.
    initial
    begin
        hold_off = 1'b0;
        wait (rst_n);
        repeat (600) @(posedge clk);
        hold_off = 1'b1;
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
    end

    // Receiver and checker
    initial
    begin
        answer_t a;
        int      gap;
        rsp.ready <= 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (rsp.valid && rsp.ready)
            begin
                if (answers.size() == 0)
                begin
                    $error("item with no expectation waiting");
                    errors++;
                end
                else
                begin
                    a = answers.pop_front();
                    if (rsp.found !== a.found)
                    begin
                        $error("found exp %0d got %0d", a.found, rsp.found);
                        errors++;
                    end
                    if (rsp.neighbor_key !== a.nkey)
                    begin
                        $error("neighbor_key exp %0d got %0d", a.nkey, rsp.neighbor_key);
                        errors++;
                    end
                    if (rsp.neighbor_value !== a.nval)
                    begin
                        $error("neighbor_value exp %0d got %0d", a.nval,
                               rsp.neighbor_value);
                        errors++;
                    end
                    if (rsp.table_full !== a.full)
                    begin
                        $error("table_full exp %0d got %0d", a.full, rsp.table_full);
                        errors++;
                    end
                end
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
                if (gap > 0 || hold_off)
                begin
                    rsp.ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                    while (hold_off)
                        @(posedge clk);
                    rsp.ready <= 1'b1;
                end
            end
            else if (!rsp.ready && !hold_off)
                rsp.ready <= 1'b1;
            else if (rsp.ready && hold_off)
                rsp.ready <= 1'b0;
        end
    end

    // End of run
    initial
    begin
        wait (stim_done);
        while (answers.size() > 0)
            @(posedge clk);
        repeat (CAP + 20) @(posedge clk);
        if (errors == 0)
            $display("ordered_map_neighbor_query verification clean");
        else
            $display("ordered_map_neighbor_query verification failed");
        $finish;
    end
endmodule

[sim.f]
rtl/core/omnq_pkg.sv
rtl/core/omnq_if.sv
rtl/core/omnq_front.sv
rtl/core/omnq_back.sv
rtl/core/ordered_map_neighbor_query.sv
rtl/core/omnq_checker.sv
sim/tb.sv
